// ----- hdl/depth_to_point_backprojection_core_defines.svh -----
// assertion macros shared by the back-projection core rtl
// depends on nothing; the including module provides clk and arst_n
`ifndef DEPTH_TO_POINT_BACKPROJECTION_CORE_DEFINES_SVH
`define DEPTH_TO_POINT_BACKPROJECTION_CORE_DEFINES_SVH
`ifndef SYNTH
// concurrent check, disabled while reset is asserted
`define DTPB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("dtpb assertion failed");
// condition this cycle implies a consequence on the next cycle
`define DTPB_ASSERT_NEXT(lbl, cond, conseq) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("dtpb assertion failed");
`else
`define DTPB_ASSERT(lbl, prop)
`define DTPB_ASSERT_NEXT(lbl, cond, conseq)
`endif
`endif

// ----- hdl/dtpb_pkg.sv -----
// shared types and constants of the depth back-projection core
// depends on nothing
`default_nettype none
package dtpb_pkg;

	localparam int DEPTH_W    = 16;
	localparam int COLOR_W    = 8;
	localparam int CENTER_W   = 15;
	localparam int INV_W      = 21;
	localparam int SIZE_W     = 12;
	localparam int COORD_W    = 32;
	localparam int FOCAL_FRAC = 24;
	localparam int PP_LO_W    = 18;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X     = 3'd0,
		CFG_CENTER_Y     = 3'd1,
		CFG_INV_FOCAL_X  = 3'd2,
		CFG_INV_FOCAL_Y  = 3'd3,
		CFG_IMAGE_WIDTH  = 3'd4,
		CFG_IMAGE_HEIGHT = 3'd5
	} cfg_idx_t;

	localparam logic [CENTER_W-1:0] RST_CENTER_X    = 15'd5120;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 15'd3840;
	localparam logic [INV_W-1:0]    RST_INV_FOCAL   = 21'd31957;
	localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH  = 12'd640;
	localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT = 12'd480;

	typedef struct packed {
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [INV_W-1:0]    inv_focal_x;
		logic [INV_W-1:0]    inv_focal_y;
	} cam_cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

endpackage
`default_nettype wire

// ----- hdl/dtpb_front.sv -----
// front end: raster position counters and frame-end classification
// depends on dtpb_pkg and the assertion macro header
`default_nettype none
`include "depth_to_point_backprojection_core_defines.svh"
module dtpb_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [dtpb_pkg::SIZE_W-1:0]      image_width,
	input  logic [dtpb_pkg::SIZE_W-1:0]      image_height,
	output logic [$clog2(MAX_WIDTH)-1:0]     col,
	output logic [$clog2(MAX_HEIGHT)-1:0]    row,
	output logic                             frame_end
);
	import dtpb_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int SXW   = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
	localparam int SYW   = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [SXW-1:0]   w_reg, w_eff;
	logic [SYW-1:0]   h_reg, h_eff;
	logic             last_col, last_row;

	// zero acts as one, oversize clamps to the maximum
	always_comb begin
		w_reg = SXW'(image_width);
		h_reg = SYW'(image_height);
		if (w_reg == '0) begin
			w_eff = SXW'(1);
		end else if (w_reg > SXW'(MAX_WIDTH)) begin
			w_eff = SXW'(MAX_WIDTH);
		end else begin
			w_eff = w_reg;
		end
		if (h_reg == '0) begin
			h_eff = SYW'(1);
		end else if (h_reg > SYW'(MAX_HEIGHT)) begin
			h_eff = SYW'(MAX_HEIGHT);
		end else begin
			h_eff = h_reg;
		end
		// at or beyond the last index counts as last
		last_col = SXW'(col_q) >= (w_eff - SXW'(1));
		last_row = SYW'(row_q) >= (h_eff - SYW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	assign col       = col_q;
	assign row       = row_q;
	assign frame_end = last_col && last_row;

	`DTPB_ASSERT_NEXT(a_frame_wrap, accept && frame_end, col_q == '0 && row_q == '0)

endmodule
`default_nettype wire

// ----- hdl/dtpb_fifo.sv -----
// short queue between the front end and the projection back end
// depends on the assertion macro header
`default_nettype none
`include "depth_to_point_backprojection_core_defines.svh"
module dtpb_fifo #(
	parameter int W  = 64,
	parameter int AW = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         full,
	output logic         empty
);
	localparam int DEPTH = 1 << AW;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign full    = cnt_q == (AW+1)'(DEPTH);
	assign empty   = cnt_q == '0;

	`DTPB_ASSERT(a_no_overflow, wr_en |-> !full)
	`DTPB_ASSERT(a_no_underflow, rd_en |-> !empty)

endmodule
`default_nettype wire

// ----- hdl/dtpb_proj.sv -----
// one axis of the pinhole back-projection: three-stage multiply, round, saturate
// depends on dtpb_pkg
`default_nettype none
module dtpb_proj #(
	parameter int POS_W = 11
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [POS_W-1:0]                    pos,
	input  logic [dtpb_pkg::CENTER_W-1:0]       centre,
	input  logic [dtpb_pkg::DEPTH_W-1:0]        depth,
	input  logic [dtpb_pkg::INV_W-1:0]          inv,
	output logic signed [dtpb_pkg::COORD_W-1:0] value
);
	import dtpb_pkg::*;

	localparam int DW   = (POS_W + 4 > CENTER_W) ? POS_W + 4 : CENTER_W;
	localparam int PW   = DW + DEPTH_W;
	localparam int HI_W = PW - PP_LO_W;
	localparam int MW   = PW + INV_W;
	localparam int RW   = MW + 1 - FOCAL_FRAC;
	localparam int RX   = (RW > COORD_W + 1) ? RW : COORD_W + 1;

	logic [DW-1:0]            p16, cen, diff;
	logic                     neg;
	logic [PW-1:0]            prod_s1;
	logic                     neg_s1;
	logic [PP_LO_W+INV_W-1:0] lo_s2;
	logic [HI_W+INV_W-1:0]    hi_s2;
	logic                     neg_s2;
	logic [MW:0]              rnd;
	logic [RX-1:0]            r, r_sat;
	logic [COORD_W-1:0]       res;

	always_comb begin
		p16  = DW'({pos, 4'b0000});
		cen  = DW'(centre);
		neg  = cen > p16;
		diff = neg ? (cen - p16) : (p16 - cen);
	end

	// split the wide product into two partial products
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(diff) * PW'(depth);
			neg_s1  <= neg;
			lo_s2   <= (PP_LO_W+INV_W)'(prod_s1[PP_LO_W-1:0]) * (PP_LO_W+INV_W)'(inv);
			hi_s2   <= (HI_W+INV_W)'(prod_s1[PW-1:PP_LO_W]) * (HI_W+INV_W)'(inv);
			neg_s2  <= neg_s1;
			value   <= signed'(res);
		end
	end

	// recombine, round half away from zero on the magnitude, saturate
	always_comb begin
		rnd = ((MW+1)'(hi_s2) << PP_LO_W) + (MW+1)'(lo_s2)
			+ ((MW+1)'(1) << (FOCAL_FRAC - 1));
		r = RX'(rnd[MW:FOCAL_FRAC]);
		if (neg_s2) begin
			r_sat = (r > (RX'(1) << (COORD_W - 1))) ? (RX'(1) << (COORD_W - 1)) : r;
			res   = COORD_W'(0) - r_sat[COORD_W-1:0];
		end else begin
			r_sat = (r > ((RX'(1) << (COORD_W - 1)) - RX'(1)))
				? ((RX'(1) << (COORD_W - 1)) - RX'(1)) : r;
			res   = r_sat[COORD_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/dtpb_back.sv -----
// back end: stall-together projection pipeline with the result register
// depends on dtpb_pkg, dtpb_proj and the assertion macro header
`default_nettype none
`include "depth_to_point_backprojection_core_defines.svh"
module dtpb_back #(
	parameter int COL_W = 11,
	parameter int ROW_W = 11
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dtpb_pkg::cam_cfg_t                  cam,
	input  logic                                q_empty,
	output logic                                q_pop,
	input  logic [COL_W-1:0]                    q_col,
	input  logic [ROW_W-1:0]                    q_row,
	input  logic [dtpb_pkg::DEPTH_W-1:0]        q_depth,
	input  dtpb_pkg::rgb_t                      q_rgb,
	input  logic                                q_frame_end,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [dtpb_pkg::COORD_W-1:0] point_x,
	output logic signed [dtpb_pkg::COORD_W-1:0] point_y,
	output logic [dtpb_pkg::DEPTH_W-1:0]        point_z,
	output logic                                point_valid,
	output dtpb_pkg::rgb_t                      out_rgb,
	output logic                                frame_end
);
	import dtpb_pkg::*;

	logic               en;
	logic               v_s1, v_s2, v_s3;
	logic [DEPTH_W-1:0] depth_s1, depth_s2, depth_s3;
	rgb_t               rgb_s1, rgb_s2, rgb_s3;
	logic               fe_s1, fe_s2, fe_s3;

	// whole pipeline moves when the result slot is free or being taken
	assign en    = !v_s3 || pop;
	assign q_pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			depth_s1 <= q_depth;
			rgb_s1   <= q_rgb;
			fe_s1    <= q_frame_end;
			depth_s2 <= depth_s1;
			rgb_s2   <= rgb_s1;
			fe_s2    <= fe_s1;
			depth_s3 <= depth_s2;
			rgb_s3   <= rgb_s2;
			fe_s3    <= fe_s2;
		end
	end

	// zero depth gives a zero product, so both coordinates come out zero
	dtpb_proj #(.POS_W(COL_W)) u_proj_x (
		.clk    (clk),
		.en     (en),
		.pos    (q_col),
		.centre (cam.center_x),
		.depth  (q_depth),
		.inv    (cam.inv_focal_x),
		.value  (point_x)
	);

	dtpb_proj #(.POS_W(ROW_W)) u_proj_y (
		.clk    (clk),
		.en     (en),
		.pos    (q_row),
		.centre (cam.center_y),
		.depth  (q_depth),
		.inv    (cam.inv_focal_y),
		.value  (point_y)
	);

	assign empty       = !v_s3;
	assign point_z     = depth_s3;
	assign point_valid = depth_s3 != '0;
	assign out_rgb     = rgb_s3;
	assign frame_end   = fe_s3;

	`DTPB_ASSERT(a_zero_depth_point, v_s3 && !point_valid |-> point_x == 0 && point_y == 0)

endmodule
`default_nettype wire

// ----- hdl/depth_to_point_backprojection_core.sv -----
// depth back-projection core: input queue port, config registers, front, queue, back
// depends on dtpb_pkg, dtpb_front, dtpb_fifo, dtpb_back
// usage
//   input channel: depth_mm and colour transfer on a clock edge with push high and full
//   low; pixels come in raster order, counters wrap at image_width and image_height
//   result channel: while empty is low the oldest point sits on point_x/y/z,
//   point_valid, out_red/green/blue and frame_end; it transfers on an edge with pop high
//   point_x/y are signed 1/16 mm, saturated; zero depth gives an all-zero point with
//   point_valid low; frame_end marks the last pixel of a frame
//   config channel: cfg_index/cfg_data transfer when cfg_valid is high (cfg_ready is
//   always high); write only while no pixels are in flight; unknown indexes are dropped
// timing
//   a transferred pixel passes the four-entry queue, projection stage one (difference
//   times depth), stage two (partial products with the reciprocal focal length) and
//   stage three, which recombines, rounds and saturates and is the result register;
//   empty goes low when it is loaded. throughput is one point per cycle while pop is high
// reset and stalls
//   arst_n clears the counters, the queue and the pipeline valid bits and loads the
//   default camera and image size. with pop low the pipeline freezes once a point waits,
//   the queue fills and full rises once all four entries hold pixels; nothing is dropped
`default_nettype none
module depth_to_point_backprojection_core #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [dtpb_pkg::DEPTH_W-1:0]         depth_mm,
	input  logic [dtpb_pkg::COLOR_W-1:0]         red,
	input  logic [dtpb_pkg::COLOR_W-1:0]         green,
	input  logic [dtpb_pkg::COLOR_W-1:0]         blue,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [dtpb_pkg::COORD_W-1:0]  point_x,
	output logic signed [dtpb_pkg::COORD_W-1:0]  point_y,
	output logic [dtpb_pkg::DEPTH_W-1:0]         point_z,
	output logic                                 point_valid,
	output logic [dtpb_pkg::COLOR_W-1:0]         out_red,
	output logic [dtpb_pkg::COLOR_W-1:0]         out_green,
	output logic [dtpb_pkg::COLOR_W-1:0]         out_blue,
	output logic                                 frame_end,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dtpb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dtpb_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dtpb_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int ITEM_W = COL_W + ROW_W + DEPTH_W + 3 * COLOR_W + 1;
	localparam int Q_AW   = 2;

	// camera and image size registers
	cam_cfg_t          cam_q;
	logic [SIZE_W-1:0] image_width_q, image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q.center_x    <= RST_CENTER_X;
			cam_q.center_y    <= RST_CENTER_Y;
			cam_q.inv_focal_x <= RST_INV_FOCAL;
			cam_q.inv_focal_y <= RST_INV_FOCAL;
			image_width_q     <= RST_IMAGE_WIDTH;
			image_height_q    <= RST_IMAGE_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X:     cam_q.center_x    <= cfg_data[CENTER_W-1:0];
				CFG_CENTER_Y:     cam_q.center_y    <= cfg_data[CENTER_W-1:0];
				CFG_INV_FOCAL_X:  cam_q.inv_focal_x <= cfg_data[INV_W-1:0];
				CFG_INV_FOCAL_Y:  cam_q.inv_focal_y <= cfg_data[INV_W-1:0];
				CFG_IMAGE_WIDTH:  image_width_q     <= cfg_data[SIZE_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q    <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// front end: position and frame-end tagging at input transfer
	logic              in_xfer;
	logic [COL_W-1:0]  f_col;
	logic [ROW_W-1:0]  f_row;
	logic              f_frame_end;
	rgb_t              in_rgb;

	assign in_xfer = push && !full;
	assign in_rgb  = '{red: red, green: green, blue: blue};

	dtpb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_xfer),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.col          (f_col),
		.row          (f_row),
		.frame_end    (f_frame_end)
	);

	// queue decoupling the front from the projection pipeline
	logic [ITEM_W-1:0] q_wr_data, q_rd_data;
	logic              q_empty, q_pop;
	logic [COL_W-1:0]  q_col;
	logic [ROW_W-1:0]  q_row;
	logic [DEPTH_W-1:0] q_depth;
	rgb_t              q_rgb;
	logic              q_frame_end;

	assign q_wr_data = {f_frame_end, in_rgb, depth_mm, f_row, f_col};
	assign {q_frame_end, q_rgb, q_depth, q_row, q_col} = q_rd_data;

	dtpb_fifo #(.W(ITEM_W), .AW(Q_AW)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_xfer),
		.wr_data (q_wr_data),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.full    (full),
		.empty   (q_empty)
	);

	// back end: projection and the result register
	rgb_t out_rgb;

	dtpb_back #(.COL_W(COL_W), .ROW_W(ROW_W)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cam         (cam_q),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_col       (q_col),
		.q_row       (q_row),
		.q_depth     (q_depth),
		.q_rgb       (q_rgb),
		.q_frame_end (q_frame_end),
		.empty       (empty),
		.pop         (pop),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.point_valid (point_valid),
		.out_rgb     (out_rgb),
		.frame_end   (frame_end)
	);

	assign out_red   = out_rgb.red;
	assign out_green = out_rgb.green;
	assign out_blue  = out_rgb.blue;

endmodule
`default_nettype wire
